/* src/trilinear_vector_field_interpolator_macros.svh */
// Assertion macros shared by the interpolator RTL.
// Needs signals named clk and rst in the module that uses them.
`ifndef TRILINEAR_VECTOR_FIELD_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_VECTOR_FIELD_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* src/tvfi_pkg.sv */
// Shared types, constants and the lerp function of the field interpolator.
// No dependencies.
`timescale 1ns / 1ps

package tvfi_pkg;

  localparam int DEF_GRID_X = 32;
  localparam int DEF_GRID_Y = 32;
  localparam int DEF_GRID_Z = 512;

  localparam int ADDR_W     = 19;
  localparam int FIELD_W    = 32;
  localparam int VEC_W      = 3 * FIELD_W;
  localparam int FRAC_W     = 17;
  localparam int PIPE_DEPTH = 9;

  localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'h10000;
  localparam logic [31:0]       STEPS_RESET = 32'h0100_0000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_STEPS_X,
    REG_STEPS_Y,
    REG_STEPS_Z,
    REG_INVERT_MASK
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic query;
    logic in_grid;
  } item_ctl_t;

  // floor((a*(1-f) + b*f + 1/2)), f in Q.16 up to one
  function automatic logic signed [FIELD_W-1:0] lerp(
    input logic signed [FIELD_W-1:0] a,
    input logic signed [FIELD_W-1:0] b,
    input logic [FRAC_W-1:0]         f
  );
    logic signed [FRAC_W:0] wa;
    logic signed [FRAC_W:0] wb;
    logic signed [50:0]     s;
    wa = $signed({1'b0, FRAC_ONE - f});
    wb = $signed({1'b0, f});
    s  = 51'(a) * 51'(wa) + 51'(b) * 51'(wb) + 51'sd32768;
    return s[47:16];
  endfunction

endpackage

/* src/tvfi_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tvfi_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/tvfi_locate.sv */
// One axis of the point locator: offset, scale, range check, mirror, split.
// Uses tvfi_pkg. Four register stages.
`timescale 1ns / 1ps

module tvfi_locate import tvfi_pkg::*; #(
  parameter int N = DEF_GRID_X
) (
  input  logic                    clk,
  input  logic signed [31:0]      point,
  input  logic signed [31:0]      origin,
  input  logic [31:0]             steps,
  input  logic                    invert,
  output logic [$clog2(N)-1:0]    idx,
  output logic [FRAC_W-1:0]       frac,
  output logic                    in_grid
);

  localparam int IW = $clog2(N);
  localparam int PW = IW + 16;
  localparam logic [40:0]   TOP_W = 41'(N - 1) << 16;
  localparam logic [PW-1:0] TOP_P = PW'(N - 1) << 16;

  logic signed [32:0] d;
  logic               neg2;
  logic [47:0]        a2;
  logic [47:0]        b2;
  logic [48:0]        sum;
  logic [40:0]        pos;
  logic [PW-1:0]      pos3;
  logic               in3;
  logic [PW-1:0]      posi;

  assign sum = 49'(a2) + 49'(b2[47:16]);
  assign pos = sum[48:8];
  assign posi = invert ? (TOP_P - pos3) : pos3;

  always_ff @(posedge clk) begin
    d    <= 33'(point) - 33'(origin);
    neg2 <= d[32];
    a2   <= 48'(d[31:0]) * 48'(steps[31:16]);
    b2   <= 48'(d[31:0]) * 48'(steps[15:0]);
    in3  <= !neg2 && (pos <= TOP_W);
    pos3 <= pos[PW-1:0];
    in_grid <= in3;
    // clamp the upper edge onto the last cell with a full fraction
    if (posi[PW-1:16] == IW'(N - 1)) begin
      idx  <= IW'(N - 2);
      frac <= FRAC_ONE;
    end else begin
      idx  <= posi[PW-1:16];
      frac <= {1'b0, posi[15:0]};
    end
  end

endmodule

/* src/tvfi_split.sv */
// Write path: split a linear grid address into x, y, z by reciprocal multiply.
// Uses tvfi_pkg. Four register stages, matching the locator.
`timescale 1ns / 1ps

module tvfi_split import tvfi_pkg::*; #(
  parameter int GX = DEF_GRID_X,
  parameter int GY = DEF_GRID_Y,
  parameter int GZ = DEF_GRID_Z
) (
  input  logic                   clk,
  input  logic [ADDR_W-1:0]      addr,
  input  logic [VEC_W-1:0]       wdata,
  output logic [$clog2(GX)-1:0]  x,
  output logic [$clog2(GY)-1:0]  y,
  output logic [$clog2(GZ)-1:0]  z,
  output logic                   in_range,
  output logic [VEC_W-1:0]       data
);

  localparam int XW    = $clog2(GX);
  localparam int YW    = $clog2(GY);
  localparam int ZW    = $clog2(GZ);
  localparam int YZ    = GY * GZ;
  localparam int RW    = $clog2(YZ);
  localparam int CELLS = GX * YZ;
  localparam int MW    = ADDR_W + 2;
  localparam int PRW   = ADDR_W + MW;
  localparam int S1    = ADDR_W + $clog2(YZ) + 1;
  localparam int S2    = ADDR_W + $clog2(GZ) + 1;
  localparam logic [63:0] M1 = ((64'd1 << S1) + 64'(YZ) - 64'd1) / 64'(YZ);
  localparam logic [63:0] M2 = ((64'd1 << S2) + 64'(GZ) - 64'd1) / 64'(GZ);

  logic [ADDR_W-1:0] addr1;
  logic [XW-1:0]     x1, x2, x3;
  logic              rng1, rng2, rng3;
  logic [VEC_W-1:0]  data1, data2, data3;
  logic [RW-1:0]     rem2, rem3;
  logic [YW-1:0]     y3;
  logic [PRW-1:0]    prod1, prod3;

  assign prod1 = PRW'(addr) * PRW'(M1[MW-1:0]);
  assign prod3 = PRW'(rem2) * PRW'(M2[MW-1:0]);

  always_ff @(posedge clk) begin
    addr1 <= addr;
    x1    <= XW'(prod1 >> S1);
    rng1  <= 32'(addr) < 32'(CELLS);
    data1 <= wdata;

    rem2  <= RW'(addr1 - ADDR_W'(x1) * ADDR_W'(YZ));
    x2    <= x1;
    rng2  <= rng1;
    data2 <= data1;

    y3    <= YW'(prod3 >> S2);
    rem3  <= rem2;
    x3    <= x2;
    rng3  <= rng2;
    data3 <= data2;

    z        <= ZW'(rem3 - RW'(y3) * RW'(GZ));
    y        <= y3;
    x        <= x3;
    in_range <= rng3;
    data     <= data3;
  end

endmodule

/* src/tvfi_grid.sv */
// Parity-banked grid store: eight banks so all corners of a cell read at once.
// Uses tvfi_pkg and tvfi_ram. Two register stages (address, RAM read).
`timescale 1ns / 1ps

module tvfi_grid import tvfi_pkg::*; #(
  parameter int GX = DEF_GRID_X,
  parameter int GY = DEF_GRID_Y,
  parameter int GZ = DEF_GRID_Z
) (
  input  logic                   clk,
  input  logic                   rst,
  input  item_ctl_t              ctl_in,
  input  logic [$clog2(GX)-1:0]  ix,
  input  logic [$clog2(GY)-1:0]  iy,
  input  logic [$clog2(GZ)-1:0]  iz,
  input  logic [FRAC_W-1:0]      fx_in,
  input  logic [FRAC_W-1:0]      fy_in,
  input  logic [FRAC_W-1:0]      fz_in,
  input  logic [$clog2(GX)-1:0]  wx,
  input  logic [$clog2(GY)-1:0]  wy,
  input  logic [$clog2(GZ)-1:0]  wz,
  input  logic                   wr_ok,
  input  logic [VEC_W-1:0]       wdata,
  output item_ctl_t              ctl_out,
  output logic [FRAC_W-1:0]      fx_out,
  output logic [FRAC_W-1:0]      fy_out,
  output logic [FRAC_W-1:0]      fz_out,
  output logic [VEC_W-1:0]       corner [8]
);

  localparam int XW    = $clog2(GX);
  localparam int YW    = $clog2(GY);
  localparam int ZW    = $clog2(GZ);
  localparam int HY    = (GY + 1) / 2;
  localparam int HZ    = (GZ + 1) / 2;
  localparam int DEPTH = ((GX + 1) / 2) * HY * HZ;
  localparam int BW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BW-1:0]    baddr_next [8];
  logic             bwe_next   [8];
  logic [BW-1:0]    baddr      [8];
  logic             bwe        [8];
  logic [VEC_W-1:0] bdata;
  logic [VEC_W-1:0] rdata      [8];
  item_ctl_t        ctl1;
  logic [FRAC_W-1:0] fx1, fy1, fz1;
  logic [2:0]       par1, par2;

  always_comb begin
    logic [XW-1:0] xh;
    logic [YW-1:0] yh;
    logic [ZW-1:0] zh;
    logic [BW-1:0] acc;
    for (int b = 0; b < 8; b++) begin
      if (ctl_in.query) begin
        // corner with this parity is the base index or the one above it
        xh = XW'(ix + XW'(ix[0] ^ b[2])) >> 1;
        yh = YW'(iy + YW'(iy[0] ^ b[1])) >> 1;
        zh = ZW'(iz + ZW'(iz[0] ^ b[0])) >> 1;
      end else begin
        xh = wx >> 1;
        yh = wy >> 1;
        zh = wz >> 1;
      end
      acc = BW'(xh) * BW'(HY) + BW'(yh);
      acc = acc * BW'(HZ) + BW'(zh);
      baddr_next[b] = acc;
      bwe_next[b] = ctl_in.valid && !ctl_in.query && wr_ok &&
                    ({wx[0], wy[0], wz[0]} == 3'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      ctl_out.valid <= 1'b0;
      for (int b = 0; b < 8; b++) begin
        bwe[b] <= 1'b0;
      end
    end else begin
      ctl1.valid    <= ctl_in.valid;
      ctl_out.valid <= ctl1.valid;
      for (int b = 0; b < 8; b++) begin
        bwe[b] <= bwe_next[b];
      end
    end
    ctl1.query      <= ctl_in.query;
    ctl1.in_grid    <= ctl_in.in_grid;
    ctl_out.query   <= ctl1.query;
    ctl_out.in_grid <= ctl1.in_grid;
    for (int b = 0; b < 8; b++) begin
      baddr[b] <= baddr_next[b];
    end
    bdata  <= wdata;
    par1   <= {ix[0], iy[0], iz[0]};
    par2   <= par1;
    fx1    <= fx_in;
    fy1    <= fy_in;
    fz1    <= fz_in;
    fx_out <= fx1;
    fy_out <= fy1;
    fz_out <= fz1;
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    tvfi_ram #(
      .WIDTH(VEC_W),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (bwe[b]),
      .addr (baddr[b]),
      .wdata(bdata),
      .rdata(rdata[b])
    );
  end

  // corner {i,j,k} sits in the bank whose parity is base parity xor offset
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner[c] = rdata[3'(c) ^ par2];
    end
  end

endmodule

/* src/tvfi_blend.sv */
// Trilinear blend: lerp along z, then y, then x, one register stage each.
// Uses tvfi_pkg.
`timescale 1ns / 1ps

module tvfi_blend import tvfi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  item_ctl_t                 ctl_in,
  input  logic [FRAC_W-1:0]         fx,
  input  logic [FRAC_W-1:0]         fy,
  input  logic [FRAC_W-1:0]         fz,
  input  logic [VEC_W-1:0]          corner [8],
  output logic                      done,
  output logic signed [FIELD_W-1:0] field [3],
  output logic                      inside_res
);

  logic signed [FIELD_W-1:0] zl [3][4];
  logic signed [FIELD_W-1:0] yl [3][2];
  item_ctl_t                 ctl1, ctl2;
  logic [FRAC_W-1:0]         fx1, fy1, fx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      ctl1.valid <= ctl_in.valid;
      ctl2.valid <= ctl1.valid;
      done       <= ctl2.valid;
    end
    ctl1.query   <= ctl_in.query;
    ctl1.in_grid <= ctl_in.in_grid;
    ctl2.query   <= ctl1.query;
    ctl2.in_grid <= ctl1.in_grid;
    fx1 <= fx;
    fy1 <= fy;
    fx2 <= fx1;
    for (int c = 0; c < 3; c++) begin
      for (int p = 0; p < 4; p++) begin
        zl[c][p] <= lerp(corner[2 * p][FIELD_W * c +: FIELD_W],
                         corner[2 * p + 1][FIELD_W * c +: FIELD_W], fz);
      end
      for (int i = 0; i < 2; i++) begin
        yl[c][i] <= lerp(zl[c][2 * i], zl[c][2 * i + 1], fy1);
      end
      // drop the value for writes and for points off the grid
      field[c] <= (ctl2.query && ctl2.in_grid) ? lerp(yl[c][0], yl[c][1], fx2) : '0;
    end
    inside_res <= ctl2.query && ctl2.in_grid;
  end

endmodule

/* src/trilinear_vector_field_interpolator.sv */
// Top level of the trilinear field interpolator: config registers, stage
// control and wiring. Uses tvfi_pkg, tvfi_locate, tvfi_split, tvfi_grid, tvfi_blend.
//
//   channel   ports                                         transfer when
//   ------------------------------------------------------------------------
//   item in   command, entry_address, write_field_*, point_*  start && !busy
//   result    field_x/y/z, inside_res                        done
//   config    cfg_index, cfg_data                            cfg_write
//
// One item per cycle while busy is low; every item gives one result, and
// between transfer and result it passes four stages that locate the point
// (or split a write address), one that forms the bank addresses, one that
// reads the banked grid and three that blend. busy is high only in reset;
// reset empties the pipeline, grid contents are not cleared. Results are never held.
`timescale 1ns / 1ps
`include "trilinear_vector_field_interpolator_macros.svh"

module trilinear_vector_field_interpolator import tvfi_pkg::*; #(
  parameter int GRID_X = DEF_GRID_X,
  parameter int GRID_Y = DEF_GRID_Y,
  parameter int GRID_Z = DEF_GRID_Z
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command,
  input  logic [ADDR_W-1:0]         entry_address,
  input  logic signed [FIELD_W-1:0] write_field_x,
  input  logic signed [FIELD_W-1:0] write_field_y,
  input  logic signed [FIELD_W-1:0] write_field_z,
  input  logic signed [FIELD_W-1:0] point_x,
  input  logic signed [FIELD_W-1:0] point_y,
  input  logic signed [FIELD_W-1:0] point_z,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output logic                      done,
  output logic signed [FIELD_W-1:0] field_x,
  output logic signed [FIELD_W-1:0] field_y,
  output logic signed [FIELD_W-1:0] field_z,
  output logic                      inside_res
);

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int ZW = $clog2(GRID_Z);

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        steps_per_unit_x, steps_per_unit_y, steps_per_unit_z;
  logic [2:0]         axis_invert_mask;

  logic [3:0]  valid;
  logic [3:0]  query;
  logic        accept;

  logic [XW-1:0]     ix, wx;
  logic [YW-1:0]     iy, wy;
  logic [ZW-1:0]     iz, wz;
  logic [FRAC_W-1:0] fx, fy, fz, gfx, gfy, gfz;
  logic              inx, iny, inz, wr_ok;
  logic [VEC_W-1:0]  wdata;
  item_ctl_t         ctl4, gctl;
  logic [VEC_W-1:0]  corner [8];
  logic signed [FIELD_W-1:0] field [3];

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x         <= '0;
      origin_y         <= '0;
      origin_z         <= '0;
      steps_per_unit_x <= STEPS_RESET;
      steps_per_unit_y <= STEPS_RESET;
      steps_per_unit_z <= STEPS_RESET;
      axis_invert_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    origin_x         <= cfg_data;
        REG_ORIGIN_Y:    origin_y         <= cfg_data;
        REG_ORIGIN_Z:    origin_z         <= cfg_data;
        REG_STEPS_X:     steps_per_unit_x <= cfg_data;
        REG_STEPS_Y:     steps_per_unit_y <= cfg_data;
        REG_STEPS_Z:     steps_per_unit_z <= cfg_data;
        REG_INVERT_MASK: axis_invert_mask <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], accept};
    end
    query <= {query[2:0], command == CMD_QUERY};
  end

  tvfi_locate #(.N(GRID_X)) u_loc_x (
    .clk(clk), .point(point_x), .origin(origin_x), .steps(steps_per_unit_x),
    .invert(axis_invert_mask[0]), .idx(ix), .frac(fx), .in_grid(inx)
  );

  tvfi_locate #(.N(GRID_Y)) u_loc_y (
    .clk(clk), .point(point_y), .origin(origin_y), .steps(steps_per_unit_y),
    .invert(axis_invert_mask[1]), .idx(iy), .frac(fy), .in_grid(iny)
  );

  tvfi_locate #(.N(GRID_Z)) u_loc_z (
    .clk(clk), .point(point_z), .origin(origin_z), .steps(steps_per_unit_z),
    .invert(axis_invert_mask[2]), .idx(iz), .frac(fz), .in_grid(inz)
  );

  tvfi_split #(.GX(GRID_X), .GY(GRID_Y), .GZ(GRID_Z)) u_split (
    .clk     (clk),
    .addr    (entry_address),
    .wdata   ({write_field_z, write_field_y, write_field_x}),
    .x       (wx),
    .y       (wy),
    .z       (wz),
    .in_range(wr_ok),
    .data    (wdata)
  );

  assign ctl4.valid   = valid[3];
  assign ctl4.query   = query[3];
  assign ctl4.in_grid = inx && iny && inz;

  tvfi_grid #(.GX(GRID_X), .GY(GRID_Y), .GZ(GRID_Z)) u_grid (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl4),
    .ix     (ix),
    .iy     (iy),
    .iz     (iz),
    .fx_in  (fx),
    .fy_in  (fy),
    .fz_in  (fz),
    .wx     (wx),
    .wy     (wy),
    .wz     (wz),
    .wr_ok  (wr_ok),
    .wdata  (wdata),
    .ctl_out(gctl),
    .fx_out (gfx),
    .fy_out (gfy),
    .fz_out (gfz),
    .corner (corner)
  );

  tvfi_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (gctl),
    .fx        (gfx),
    .fy        (gfy),
    .fz        (gfz),
    .corner    (corner),
    .done      (done),
    .field     (field),
    .inside_res(inside_res)
  );

  assign field_x = field[0];
  assign field_y = field[1];
  assign field_z = field[2];

  `ASSERT_IMPLIES(a_latency, accept, ##PIPE_DEPTH done)
  `ASSERT_NEXT(a_write_zero, accept && command == CMD_WRITE, ##8 (done && !inside_res))
  `ASSERT_IMPLIES(a_outside_zero, done && !inside_res,
                  field_x == '0 && field_y == '0 && field_z == '0)

endmodule
